// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for concurrent checks on a clocked interface.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication, checked at every edge including reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg
// Types and constants shared by the Braille cell encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  localparam int unsigned MAX_ROWS = 1024;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned TROW_W     = 10;

  localparam logic [7:0]       THRESHOLD_RESET = 8'd128;
  localparam logic [COL_W-1:0] COLUMNS_RESET   = 9'd40;
  localparam logic [ROW_W-1:0] ROWS_RESET      = 11'd20;

  // UTF-8 of U+2800 + pattern, and newline
  localparam logic [7:0] BYTE_LEAD = 8'hE2;
  localparam logic [7:0] BYTE_MID  = 8'hA0;
  localparam logic [7:0] BYTE_TAIL = 8'h80;
  localparam logic [7:0] BYTE_NL   = 8'h0A;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COLUMNS   = 2'd1,
    REG_ROWS      = 2'd2
  } reg_index_t;

  // Per-pixel decode handed from the scan counters to the cell store
  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [2:0]        dot;
    logic              lit;
    logic              fresh;
    logic              emit_cell;
    logic              emit_nl;
  } scan_t;

  // Byte group handed from the cell store to the output buffer
  typedef struct packed {
    logic [7:0] pattern;
    logic       emit_cell;
    logic       emit_nl;
  } group_t;

endpackage

`default_nettype wire

// ===== rtl/bcpe_scan.sv =====
// ----------------------------------------------------------------------------
// bcpe_scan
// Configuration registers and raster position counters; decodes each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_scan import bcpe_pkg::*; #(
  parameter int unsigned MAX_COLS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]            pixel,
  input  wire logic                  take,
  output scan_t                      scan
);

  logic [7:0]        threshold;
  logic [COL_W-1:0]  columns;
  logic [ROW_W-1:0]  rows;
  logic [COL_W-1:0]  pixel_column;
  logic [1:0]        row_in_cell;
  logic [TROW_W-1:0] text_row;

  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic             x;
  logic             row_end;
  logic             frame_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      columns   <= COLUMNS_RESET;
      rows      <= ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data[7:0];
        REG_COLUMNS:   columns   <= cfg_data[COL_W-1:0];
        REG_ROWS:      rows      <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns == '0) begin
      cols_eff = COL_W'(1);
    end else if (32'(columns) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = columns;
    end
    if (rows == '0) begin
      rows_eff = ROW_W'(1);
    end else if (32'(rows) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = rows;
    end
  end

  assign x         = pixel_column[0];
  assign row_end   = ({1'b0, pixel_column} + (COL_W+1)'(1)) >= {cols_eff, 1'b0};
  assign frame_end = ({1'b0, text_row} + (TROW_W+1)'(1)) >= rows_eff;

  always_comb begin
    scan.cell_idx  = pixel_column[COL_W-1:1];
    scan.dot       = (row_in_cell != 2'd3) ? ({1'b0, row_in_cell} + (x ? 3'd3 : 3'd0))
                                           : (x ? 3'd7 : 3'd6);
    scan.lit       = pixel > threshold;
    scan.fresh     = (row_in_cell == 2'd0) && !x;
    scan.emit_cell = (row_in_cell == 2'd3) && x;
    scan.emit_nl   = (row_in_cell == 2'd3) && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      row_in_cell  <= '0;
      text_row     <= '0;
    end else if (take) begin
      if (row_end) begin
        pixel_column <= '0;
        if (row_in_cell == 2'd3) begin
          row_in_cell <= '0;
          text_row    <= frame_end ? '0 : text_row + TROW_W'(1);
        end else begin
          row_in_cell <= row_in_cell + 2'd1;
        end
      end else begin
        pixel_column <= pixel_column + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcpe_cell_store.sv =====
// ----------------------------------------------------------------------------
// bcpe_cell_store
// Dot accumulator memory with one read-modify-write stage and write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_cell_store import bcpe_pkg::*; #(
  parameter int unsigned MAX_COLS = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  take,
  input  wire scan_t scan,
  output logic       can_take,
  output logic       grp_valid,
  input  wire logic  grp_ready,
  output group_t     grp
);

  localparam int unsigned ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [7:0]        mem [MAX_COLS];

  logic              s1_valid;
  scan_t             s1_scan;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_store;
  logic [7:0]        rdata;

  logic [CELL_W+ADDR_W-1:0] cell_ext;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_hit;
  logic                     fwd;
  logic [7:0]               s1_pattern;
  logic                     s1_emit;
  logic                     s1_adv;

  assign cell_ext = {{ADDR_W{1'b0}}, scan.cell_idx};
  assign rd_addr  = cell_ext[ADDR_W-1:0];
  assign rd_hit   = 32'(scan.cell_idx) < MAX_COLS;

  // A valid in-range stage writes back as a new item is taken, so pass its value along
  assign fwd = s1_valid && s1_store && (s1_addr == rd_addr);

  assign s1_pattern = (s1_scan.fresh ? 8'h00 : rdata)
                    | (s1_scan.lit ? (8'h01 << s1_scan.dot) : 8'h00);
  assign s1_emit    = s1_scan.emit_cell || s1_scan.emit_nl;
  assign s1_adv     = s1_valid && (!s1_emit || grp_ready);
  assign can_take   = !s1_valid || s1_adv;

  assign grp_valid     = s1_valid && s1_emit;
  assign grp.pattern   = s1_store ? s1_pattern : 8'h00;
  assign grp.emit_cell = s1_scan.emit_cell;
  assign grp.emit_nl   = s1_scan.emit_nl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_scan  <= scan;
      s1_addr  <= rd_addr;
      s1_store <= rd_hit;
      rdata    <= fwd ? s1_pattern : mem[rd_addr];
    end
    if (s1_adv && s1_store) begin
      mem[s1_addr] <= s1_pattern;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcpe_out_buffer.sv =====
// ----------------------------------------------------------------------------
// bcpe_out_buffer
// Holds one byte group and sends its bytes one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_out_buffer import bcpe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   grp_valid,
  output logic        grp_ready,
  input  wire group_t grp,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [7:0]  out_byte,
  output logic        last
);

  logic       og_valid;
  group_t     og;
  logic [1:0] idx;

  logic [1:0] final_idx;
  logic       at_final;
  logic       load;

  assign final_idx = og.emit_cell ? (og.emit_nl ? 2'd3 : 2'd2) : 2'd0;
  assign at_final  = idx == final_idx;
  assign grp_ready = !og_valid || (out_ready && at_final);
  assign load      = grp_valid && grp_ready;

  assign out_valid = og_valid;
  assign last      = at_final;

  always_comb begin
    if (!og.emit_cell) begin
      out_byte = BYTE_NL;
    end else begin
      case (idx)
        2'd0:    out_byte = BYTE_LEAD;
        2'd1:    out_byte = BYTE_MID | {6'b0, og.pattern[7:6]};
        2'd2:    out_byte = BYTE_TAIL | {2'b0, og.pattern[5:0]};
        default: out_byte = BYTE_NL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      og_valid <= 1'b0;
    end else if (load) begin
      og_valid <= 1'b1;
    end else if (out_ready && at_final) begin
      og_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      og  <= grp;
      idx <= 2'd0;
    end else if (og_valid && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/braille_cell_pixel_encoder.sv =====
// ----------------------------------------------------------------------------
// braille_cell_pixel_encoder
// Grayscale raster to UTF-8 Braille text, one pixel in, bytes out.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    pixel
// out      source     out_valid / out_ready  out_byte, last
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel is taken every cycle unless a byte group waits for the output buffer;
// the first byte of its group shows after the read-modify-write stage and the
// output buffer register it. A cell group is three bytes, four with a newline,
// sent one per cycle, so on the fourth pixel row in_ready drops while the next
// group waits. Reset clears counters and restores register defaults; the cell
// memory needs no clearing. A stall on out holds the byte group, then the
// read-modify-write stage once it holds a group, and in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module braille_cell_pixel_encoder import bcpe_pkg::*; #(
  parameter int unsigned MAX_COLS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            pixel,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  scan_t  scan;
  group_t grp;
  logic   take;
  logic   grp_valid;
  logic   grp_ready;

  assign take = in_valid && in_ready;

  bcpe_scan #(
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .take      (take),
    .scan      (scan)
  );

  bcpe_cell_store #(
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .scan      (scan),
    .can_take  (in_ready),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  bcpe_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== rtl/bcpe_checker.sv =====
// ----------------------------------------------------------------------------
// bcpe_checker
// Port-level checks on the encoder's byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bcpe_checker import bcpe_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last
);

  // hold a stalled byte
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last))

  // nothing pending right after reset
  `ASSERT_NXT_ALWAYS(a_reset_idle, clk, rst, !out_valid)

  // a lead byte never ends a group
  `ASSERT_IMP(a_lead_not_last, clk, rst, out_valid && out_byte == BYTE_LEAD, !last)

  // a newline always ends its group
  `ASSERT_IMP(a_nl_last, clk, rst, out_valid && out_byte == BYTE_NL, last)

endmodule

bind braille_cell_pixel_encoder bcpe_checker u_checker (.*);

`default_nettype wire
